// File: rtl/core/golay_24_12_codec_top_macros.svh
// Assertion helpers shared by the codec RTL.
`ifndef GOLAY_24_12_CODEC_TOP_MACROS_SVH
`define GOLAY_24_12_CODEC_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GOL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GOL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/gol_pkg.sv
package gol_pkg;

	localparam int unsigned DataW = 12;
	localparam int unsigned WordW = 24;
	localparam int unsigned Rows  = 12;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	// Rows of the parity matrix; data bit 11 selects row 0.
	localparam logic [DataW-1:0] GolB [Rows] = '{
		12'hDC5, 12'hB8B, 12'h717, 12'hE2D, 12'hC5B, 12'h8B7,
		12'h16F, 12'h2DD, 12'h5B9, 12'hB71, 12'h6E3, 12'hFFE
	};

	// Syndrome stage payload. For encode, syn holds the parity.
	typedef struct packed {
		mode_t            mode;
		logic [DataW-1:0] data;
		logic [DataW-1:0] syn;
	} s1_t;

	// First search stage payload. For encode, tval holds the parity.
	typedef struct packed {
		mode_t            mode;
		logic [DataW-1:0] data;
		logic             syn_zero;
		logic             fixed;
		logic [DataW-1:0] edata;
		logic [DataW-1:0] tval;
	} s2_t;

	typedef struct packed {
		logic             uncorrectable;
		logic             corrected;
		logic [WordW-1:0] word_out;
	} res_t;

	function automatic logic [DataW-1:0] mul_b(input logic [DataW-1:0] v);
		logic [DataW-1:0] acc;
		acc = '0;
		for (int i = 0; i < Rows; i++) begin
			if (v[DataW-1-i]) begin
				acc = acc ^ GolB[i];
			end
		end
		return acc;
	endfunction

	function automatic logic [3:0] weight12(input logic [DataW-1:0] v);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < DataW; k++) begin
			n = n + 4'(v[k]);
		end
		return n;
	endfunction

endpackage

// File: rtl/core/golay_24_12_codec_top.sv
// Extended Golay (24,12,8) encoder and decoder on one stream. Each input
// transaction selects encode or decode in tuser and returns exactly one output
// transaction, in order. The path has three register stages (syndrome, first
// search with the second syndrome product, second search with correction),
// and one transaction per cycle is sustained while the output side keeps
// tready high. Decode corrects any error of up to three bits; a four-bit
// error raises the uncorrectable flag and returns the received data bits
// unchanged.
`include "golay_24_12_codec_top_macros.svh"

module golay_24_12_codec_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [23:0] word_in
	input  logic [0:0]  s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [23:0] word_out
	output logic [1:0]  m_axis_tuser   // [0] corrected, [1] uncorrectable
);

	logic          v1;
	logic          r1;
	gol_pkg::s1_t  d1;
	logic          v2;
	logic          r2;
	gol_pkg::s2_t  d2;
	gol_pkg::res_t res;

	gol_syn u_syn (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.mode      (gol_pkg::mode_t'(s_axis_tuser[0])),
		.word_in   (s_axis_tdata),
		.out_valid (v1),
		.out_ready (r1),
		.out_data  (d1)
	);

	gol_srch u_srch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_data   (d1),
		.out_valid (v2),
		.out_ready (r2),
		.out_data  (d2)
	);

	gol_fix u_fix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_data   (d2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = res.word_out;
	assign m_axis_tuser = {res.uncorrectable, res.corrected};

	// The input side only stalls when every stage is full and the output waits.
	`GOL_ASSERT_IMP(a_full_stall, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled while pipeline has room")
	`GOL_ASSERT_IMP(a_flags_excl, clk, arst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "corrected and uncorrectable both set")
	`GOL_ASSERT_IMP(a_dec_upper, clk, arst_n, m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]), m_axis_tdata[23:12] == 12'd0, "decode result has upper bits set")
	`GOL_ASSERT_NXT(a_stage_fill, clk, arst_n, v2 && r2, m_axis_tvalid, "stage two transaction lost")

endmodule

// File: rtl/core/gol_syn.sv
// Stage 1: parity for encode, first syndrome for decode.
module gol_syn (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gol_pkg::mode_t mode,
	input  logic [23:0]    word_in,
	output logic           out_valid,
	input  logic           out_ready,
	output gol_pkg::s1_t   out_data
);

	logic             vld_s1;
	gol_pkg::s1_t     pay_s1;
	logic [11:0]      data_c;
	logic [11:0]      par_c;

	assign in_ready = !vld_s1 || out_ready;

	always_comb begin
		if (mode == gol_pkg::MODE_DEC) begin
			data_c = word_in[23:12];
			par_c  = word_in[11:0] ^ gol_pkg::mul_b(word_in[23:12]);
		end else begin
			data_c = word_in[11:0];
			par_c  = gol_pkg::mul_b(word_in[11:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pay_s1.mode <= mode;
			pay_s1.data <= data_c;
			pay_s1.syn  <= par_c;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = pay_s1;

endmodule

// File: rtl/core/gol_srch.sv
// Stage 2: error search on the first syndrome and the second syndrome product.
module gol_srch (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  gol_pkg::s1_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output gol_pkg::s2_t out_data
);

	logic         vld_s2;
	gol_pkg::s2_t pay_s2;
	logic         fixed_c;
	logic [11:0]  edata_c;

	assign in_ready = !vld_s2 || out_ready;

	// Parity-only errors first, then one data bit plus up to two parity bits.
	// Scanning downward leaves the lowest matching row in place.
	always_comb begin
		fixed_c = 1'b0;
		edata_c = '0;
		for (int i = gol_pkg::Rows - 1; i >= 0; i--) begin
			if (gol_pkg::weight12(in_data.syn ^ gol_pkg::GolB[i]) <= 4'd2) begin
				fixed_c = 1'b1;
				edata_c = 12'(1) << (gol_pkg::DataW - 1 - i);
			end
		end
		if (gol_pkg::weight12(in_data.syn) <= 4'd3) begin
			fixed_c = 1'b1;
			edata_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pay_s2.mode     <= in_data.mode;
			pay_s2.data     <= in_data.data;
			pay_s2.syn_zero <= (in_data.syn == '0);
			pay_s2.fixed    <= fixed_c;
			pay_s2.edata    <= edata_c;
			pay_s2.tval     <= (in_data.mode == gol_pkg::MODE_DEC) ?
				gol_pkg::mul_b(in_data.syn) : in_data.syn;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = pay_s2;

endmodule

// File: rtl/core/gol_fix.sv
// Stage 3: search on the second syndrome, correction and result register.
module gol_fix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gol_pkg::s2_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output gol_pkg::res_t out_data
);

	logic          vld_s3;
	gol_pkg::res_t pay_s3;
	gol_pkg::res_t res_c;
	logic          hit_c;
	logic [11:0]   err_c;

	assign in_ready = !vld_s3 || out_ready;

	always_comb begin
		hit_c = 1'b0;
		err_c = '0;
		for (int i = gol_pkg::Rows - 1; i >= 0; i--) begin
			if (gol_pkg::weight12(in_data.tval ^ gol_pkg::GolB[i]) <= 4'd2) begin
				hit_c = 1'b1;
				err_c = in_data.tval ^ gol_pkg::GolB[i];
			end
		end
		if (gol_pkg::weight12(in_data.tval) <= 4'd3) begin
			hit_c = 1'b1;
			err_c = in_data.tval;
		end
	end

	always_comb begin
		res_c = '0;
		if (in_data.mode == gol_pkg::MODE_ENC) begin
			res_c.word_out = {in_data.data, in_data.tval};
		end else if (in_data.syn_zero) begin
			res_c.word_out = {12'd0, in_data.data};
		end else if (in_data.fixed) begin
			res_c.word_out  = {12'd0, in_data.data ^ in_data.edata};
			res_c.corrected = 1'b1;
		end else if (hit_c) begin
			res_c.word_out  = {12'd0, in_data.data ^ err_c};
			res_c.corrected = 1'b1;
		end else begin
			res_c.word_out      = {12'd0, in_data.data};
			res_c.uncorrectable = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pay_s3 <= res_c;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = pay_s3;

endmodule

// File: tb/sv/golay_stream_monitor.sv
`timescale 1ns / 100ps

// Watches both stream channels of the Golay codec, predicts the result of
// every input transaction and compares each output transaction against the
// oldest prediction still pending.
module golay_stream_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [23:0] word_in
	input  logic [0:0]  s_axis_tuser,  // [0] mode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,  // [23:0] word_out
	input  logic [1:0]  m_axis_tuser,  // [0] corrected, [1] uncorrectable
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic        uncorrectable;
		logic        corrected;
		logic [23:0] word_out;
	} codec_result_t;

	// Rows of the parity matrix; data bit 11 selects the first row.
	localparam logic [11:0] PARITY_ROWS [12] = '{
		12'b110111000101, 12'b101110001011, 12'b011100010111, 12'b111000101101,
		12'b110001011011, 12'b100010110111, 12'b000101101111, 12'b001011011101,
		12'b010110111001, 12'b101101110001, 12'b011011100011, 12'b111111111110
	};

	codec_result_t expected_results [$];

	function automatic logic [11:0] times_parity(input logic [11:0] v);
		logic [11:0] acc;
		acc = '0;
		for (int i = 0; i < 12; i++) begin
			if (v[11-i]) begin
				acc ^= PARITY_ROWS[i];
			end
		end
		return acc;
	endfunction

	function automatic codec_result_t golay_expected(input gol_pkg::mode_t mode,
		input logic [23:0] word);
		codec_result_t res;
		logic [11:0]   data;
		logic [11:0]   syn;
		logic [11:0]   syn2;
		logic [11:0]   err;
		logic          found;
		res   = '0;
		data  = word[23:12];
		err   = '0;
		found = 1'b0;
		if (mode == gol_pkg::MODE_ENC) begin
			res.word_out = {word[11:0], times_parity(word[11:0])};
			return res;
		end
		syn = word[11:0] ^ times_parity(data);
		if (syn == '0) begin
			res.word_out = {12'h000, data};
			return res;
		end
		// Errors confined to the parity half leave the data untouched.
		if ($countones(syn) <= 3) begin
			found = 1'b1;
		end
		for (int i = 0; i < 12; i++) begin
			if (!found && $countones(syn ^ PARITY_ROWS[i]) <= 2) begin
				found = 1'b1;
				err   = 12'h800 >> i;
			end
		end
		if (!found) begin
			syn2 = times_parity(syn);
			if ($countones(syn2) <= 3) begin
				found = 1'b1;
				err   = syn2;
			end
			for (int i = 0; i < 12; i++) begin
				if (!found && $countones(syn2 ^ PARITY_ROWS[i]) <= 2) begin
					found = 1'b1;
					err   = syn2 ^ PARITY_ROWS[i];
				end
			end
		end
		if (found) begin
			res.word_out  = {12'h000, data ^ err};
			res.corrected = 1'b1;
		end else begin
			res.word_out      = {12'h000, data};
			res.uncorrectable = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		codec_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(
					golay_expected(gol_pkg::mode_t'(s_axis_tuser[0]), s_axis_tdata));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("output transaction with no prediction pending: word_out %h", m_axis_tdata);
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata !== want.word_out) begin
						$error("word_out mismatch: expected %h, actual %h",
							want.word_out, m_axis_tdata);
						failures++;
					end
					if (m_axis_tuser[0] !== want.corrected) begin
						$error("corrected mismatch: expected %b, actual %b",
							want.corrected, m_axis_tuser[0]);
						failures++;
					end
					if (m_axis_tuser[1] !== want.uncorrectable) begin
						$error("uncorrectable mismatch: expected %b, actual %b",
							want.uncorrectable, m_axis_tuser[1]);
						failures++;
					end
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// File: tb/sv/tb_golay_24_12_codec_top.sv
`timescale 1ns / 100ps

module tb_golay_24_12_codec_top;

	localparam int StallLimit = 5000;
	localparam int DrainCycles = 20;
	localparam int RandomPerPhase = 500;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // [23:0] word_in
	logic [0:0]  s_axis_tuser;  // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // [23:0] word_out
	logic [1:0]  m_axis_tuser;  // [0] corrected, [1] uncorrectable

	int failures;
	int outstanding;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	golay_24_12_codec_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	golay_stream_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	// Builds valid codewords for the decode stimulus.
	function automatic logic [23:0] codeword_of(input logic [11:0] data);
		logic [11:0] par;
		par = '0;
		for (int i = 0; i < gol_pkg::Rows; i++) begin
			if (data[11-i]) begin
				par ^= gol_pkg::GolB[i];
			end
		end
		return {data, par};
	endfunction

	function automatic logic [23:0] error_pattern(input int weight);
		logic [23:0] e;
		e = '0;
		while ($countones(e) < weight) begin
			e[$urandom_range(23)] = 1'b1;
		end
		return e;
	endfunction

	task automatic send_item(input gol_pkg::mode_t mode, input logic [23:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= mode;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= StallLimit) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [23:0] cw;
		int          pick;
		int          sender_pct [4];
		int          receiver_pct [4];
		sender_pct     = '{0, 62, 0, 35};
		receiver_pct   = '{0, 0, 62, 35};
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = gol_pkg::MODE_ENC;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Encode extremes, including junk in the ignored upper half.
		send_item(gol_pkg::MODE_ENC, 24'h000000);
		send_item(gol_pkg::MODE_ENC, 24'h000FFF);
		send_item(gol_pkg::MODE_ENC, 24'hFFF000);
		send_item(gol_pkg::MODE_ENC, 24'hFFFFFF);
		send_item(gol_pkg::MODE_ENC, 24'h000800);
		send_item(gol_pkg::MODE_ENC, 24'h5A5001);

		// Decode: clean words, then errors in parity, data and both halves.
		send_item(gol_pkg::MODE_DEC, codeword_of(12'h000));
		send_item(gol_pkg::MODE_DEC, codeword_of(12'hFFF));
		cw = codeword_of(12'hA5C);
		send_item(gol_pkg::MODE_DEC, cw);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'h000001);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'h000007);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'h800000);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'h001000);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'hC00000);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'hE00000);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'h801001);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'hC00001);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'h400003);
		// Four flipped bits can never be corrected.
		send_item(gol_pkg::MODE_DEC, cw ^ 24'hF00000);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'h00000F);
		send_item(gol_pkg::MODE_DEC, cw ^ 24'hC00003);
		send_item(gol_pkg::MODE_DEC, 24'hFFFFFF);
		send_item(gol_pkg::MODE_DEC, 24'h000FFF);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = sender_pct[phase];
			recv_stall_pct = receiver_pct[phase];
			for (int n = 0; n < RandomPerPhase; n++) begin
				pick = $urandom_range(99);
				if (pick < 25) begin
					send_item(gol_pkg::MODE_ENC, 24'($urandom));
				end else if (pick < 35) begin
					send_item(gol_pkg::MODE_DEC, 24'($urandom));
				end else begin
					cw = codeword_of(12'($urandom));
					send_item(gol_pkg::MODE_DEC, cw ^ error_pattern($urandom_range(4)));
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/gol_pkg.sv
rtl/core/gol_syn.sv
rtl/core/gol_srch.sv
rtl/core/gol_fix.sv
rtl/core/golay_24_12_codec_top.sv
tb/sv/golay_stream_monitor.sv
tb/sv/tb_golay_24_12_codec_top.sv
